[sv/irsm_pkg.sv]
`timescale 1ns / 1ps

package irsm_pkg;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam int ADDR_W = 32;

   typedef logic [ADDR_W-1:0] addr_type;

   // one stored range and its occupancy
   typedef struct packed {
      logic     valid;
      addr_type lo;
      addr_type hi;
   } entry_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic ins;
      logic pop;
   } cell_ctl_type;

   // true when range a sorts ahead of range b
   function automatic logic goes_before(addr_type alo, addr_type ahi,
                                        addr_type blo, addr_type bhi);
      logic res;
      if (alo != blo) begin
         res = (alo < blo);
      end else begin
         res = (ahi > bhi);
      end
      return res;
   endfunction

endpackage

[sv/irsm_req_if.sv]
`timescale 1ns / 1ps

interface irsm_req_if;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [31:0]           range_low;
   logic [31:0]           range_high;

   modport source (output valid, output cmd, output range_low, output range_high,
                   input ready);
   modport sink   (input valid, input cmd, input range_low, input range_high,
                   output ready);
endinterface

[sv/irsm_rsp_if.sv]
`timescale 1ns / 1ps

interface irsm_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [31:0]           merged_low;
   logic [31:0]           merged_high;
   logic                  last_range;
   logic                  set_empty;
   logic                  overflow;

   modport source (output valid, output merged_low, output merged_high,
                   output last_range, output set_empty, output overflow,
                   input ready);
   modport sink   (input valid, input merged_low, input merged_high,
                   input last_range, input set_empty, input overflow,
                   output ready);
endinterface

[sv/irsm_cell.sv]
`timescale 1ns / 1ps

module irsm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  irsm_pkg::cell_ctl_type ctl,
   input  irsm_pkg::entry_type   new_entry,
   input  logic                  prev_take,
   input  irsm_pkg::entry_type   prev_entry,
   input  irsm_pkg::entry_type   next_entry,
   output logic                  take,
   output irsm_pkg::entry_type   entry
);
   import irsm_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new range lands here or further up when this cell is empty or the range sorts ahead of our entry
   assign take = !entry_ff.valid ||
                 goes_before(new_entry.lo, new_entry.hi, entry_ff.lo, entry_ff.hi);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = next_entry;
      end else if (ctl.ins && take) begin
         if (prev_take) begin
            entry_in = prev_entry;
         end else begin
            entry_in       = new_entry;
            entry_in.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.lo <= entry_in.lo;
      entry_ff.hi <= entry_in.hi;
   end

   assign entry = entry_ff;

endmodule

[sv/ip_range_sort_merge_core.sv]
`timescale 1ns / 1ps

// Sorted address-range store with merge on finish. Ranges are held in a chain
// of MAX_RANGES cells kept sorted by low address ascending, then high address
// descending; a load is broadcast along the chain and slots into place while
// the entries behind it move one cell down, so the block can take the next
// item right after a load. A finish drains the chain toward the head one entry
// per cycle through a merge register, unless a closed range must wait for room
// in the output register; no item is taken until the walk is done. Results
// pass through an output register, the last one carries last_range; an empty
// store answers with one result flagged set_empty. Loads into a full store are
// dropped and reported by the overflow flag of every result of the next
// finish.
module ip_range_sort_merge_core #(
   parameter int MAX_RANGES = 64
) (
   input  logic       clock,
   input  logic       reset,
   irsm_req_if.sink   req_chan,
   irsm_rsp_if.source rsp_chan
);
   import irsm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   // chain wiring
   entry_type              cell_q [MAX_RANGES];
   logic [MAX_RANGES-1:0]  take;
   logic [MAX_RANGES-1:0]  valid_vec;
   cell_ctl_type           ctl;
   entry_type              new_entry;
   entry_type              empty_entry;

   // control and merge state
   logic     state_ff, state_in;
   logic     overflow_seen_ff, overflow_seen_in;
   logic     ovf_run_ff, ovf_run_in;
   logic     have_cur_ff, have_cur_in;
   addr_type cur_lo_ff, cur_lo_in;
   addr_type cur_hi_ff, cur_hi_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   addr_type rsp_lo_ff, rsp_lo_in;
   addr_type rsp_hi_ff, rsp_hi_in;
   logic     rsp_last_ff, rsp_last_in;
   logic     rsp_empty_ff, rsp_empty_in;
   logic     rsp_ovf_ff, rsp_ovf_in;

   logic      req_fire, load_fire, finish_fire, full;
   entry_type head;
   logic      out_free, drop, join_ok, split, pop, emit_mid, emit_last;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_fire      = req_fire && (req_chan.cmd == CMD_LOAD);
   assign finish_fire    = req_fire && (req_chan.cmd == CMD_FINISH);

   // store is full once the tail cell holds a range
   assign full = cell_q[MAX_RANGES-1].valid;

   assign new_entry.valid   = 1'b1;
   assign new_entry.lo      = req_chan.range_low;
   assign new_entry.hi      = req_chan.range_high;
   assign empty_entry.valid = 1'b0;
   assign empty_entry.lo    = '0;
   assign empty_entry.hi    = '0;

   // head of the chain feeds the merge register during a walk
   assign head     = cell_q[0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // contained range is dropped
   assign drop     = (head.hi <= cur_hi_ff);
   // overlap or touch test at 33 bits so the top address does not wrap
   assign join_ok  = ({1'b0, head.lo} <= ({1'b0, cur_hi_ff} + 33'd1));
   assign split    = have_cur_ff && !drop && !join_ok;
   // a split needs room in the output register to hand off the closed range
   assign pop       = (state_ff == ST_WALK) && head.valid && (!split || out_free);
   assign emit_mid  = pop && split;
   assign emit_last = (state_ff == ST_WALK) && !head.valid && out_free;

   assign ctl.ins = load_fire && !full;
   assign ctl.pop = pop;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_RANGES; gi++) begin : g_cell
         irsm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_take  ((gi == 0) ? 1'b0 : take[(gi == 0) ? 0 : gi-1]),
            .prev_entry ((gi == 0) ? empty_entry : cell_q[(gi == 0) ? 0 : gi-1]),
            .next_entry ((gi == MAX_RANGES-1) ? empty_entry :
                         cell_q[(gi == MAX_RANGES-1) ? gi : gi+1]),
            .take       (take[gi]),
            .entry      (cell_q[gi])
         );
         assign valid_vec[gi] = cell_q[gi].valid;
      end
   endgenerate

   always_comb begin
      state_in         = state_ff;
      overflow_seen_in = overflow_seen_ff;
      ovf_run_in       = ovf_run_ff;
      have_cur_in      = have_cur_ff;
      cur_lo_in        = cur_lo_ff;
      cur_hi_in        = cur_hi_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (load_fire && full) begin
         overflow_seen_in = 1'b1;
      end

      // finish: latch the overflow flag for this run and start draining
      if (finish_fire) begin
         ovf_run_in       = overflow_seen_ff;
         overflow_seen_in = 1'b0;
         have_cur_in      = 1'b0;
         state_in         = ST_WALK;
      end

      if (pop) begin
         have_cur_in = 1'b1;
         if (!have_cur_ff || split) begin
            cur_lo_in = head.lo;
            cur_hi_in = head.hi;
         end else if (!drop) begin
            cur_hi_in = head.hi;
         end
      end

      if (emit_mid) begin
         rsp_valid_in = 1'b1;
         rsp_lo_in    = cur_lo_ff;
         rsp_hi_in    = cur_hi_ff;
         rsp_last_in  = 1'b0;
         rsp_empty_in = 1'b0;
         rsp_ovf_in   = ovf_run_ff;
      end

      // chain drained: close the run, or report an empty store
      if (emit_last) begin
         rsp_valid_in = 1'b1;
         rsp_lo_in    = have_cur_ff ? cur_lo_ff : '0;
         rsp_hi_in    = have_cur_ff ? cur_hi_ff : '0;
         rsp_last_in  = 1'b1;
         rsp_empty_in = !have_cur_ff;
         rsp_ovf_in   = ovf_run_ff;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         overflow_seen_ff <= 1'b0;
         ovf_run_ff       <= 1'b0;
         have_cur_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         overflow_seen_ff <= overflow_seen_in;
         ovf_run_ff       <= ovf_run_in;
         have_cur_ff      <= have_cur_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cur_lo_ff    <= cur_lo_in;
      cur_hi_ff    <= cur_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.merged_low  = rsp_lo_ff;
   assign rsp_chan.merged_high = rsp_hi_ff;
   assign rsp_chan.last_range  = rsp_last_ff;
   assign rsp_chan.set_empty   = rsp_empty_ff;
   assign rsp_chan.overflow    = rsp_ovf_ff;

   // sort order check across neighboring cells
   logic chain_sorted;
   always_comb begin
      chain_sorted = 1'b1;
      for (int i = 0; i < MAX_RANGES-1; i++) begin
         if (cell_q[i].valid && cell_q[i+1].valid &&
             goes_before(cell_q[i+1].lo, cell_q[i+1].hi, cell_q[i].lo, cell_q[i].hi)) begin
            chain_sorted = 1'b0;
         end
      end
   end

   // occupied cells always form a prefix of the chain
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + {{(MAX_RANGES-1){1'b0}}, 1'b1})) == '0)
      else $error("occupied cells not contiguous");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      chain_sorted)
      else $error("range chain out of order");

   // a finish blocks further items until its walk closes
   a_finish_blocks: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> !req_chan.ready)
      else $error("item taken during finish walk");

   // an empty result is always the final one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.set_empty) |-> rsp_chan.last_range)
      else $error("empty result without last flag");

endmodule
